@@ src/cne_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cne_pkg;

  // Default upper bound on the number of cells in the grid.
  localparam int MaxCellsDef = 65536;

  // Every run of results has this many slots.
  localparam int Slots    = 27;
  localparam int SlotW    = $clog2(Slots);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(Slots - 1);

  // Field widths.
  localparam int CellW  = 16;
  localparam int WallW  = 6;
  localparam int DimW   = 9;
  localparam int PlaneW = 2 * DimW;
  localparam int TotW   = 17;
  // Signed width that holds any candidate index without overflow.
  localparam int CandW  = 20;

  // Depth of the job queue between the front and the back.
  localparam int QDepth = 2;

  // Configuration register indexes.
  localparam logic [1:0] CfgCellsX = 2'd0;
  localparam logic [1:0] CfgCellsY = 2'd1;
  localparam logic [1:0] CfgTotal  = 2'd2;

  // Wall flag bit positions.
  localparam int WallBottom = 0;
  localparam int WallTop    = 1;
  localparam int WallLeft   = 2;
  localparam int WallRight  = 3;
  localparam int WallBack   = 4;
  localparam int WallFront  = 5;

  // Grid geometry as seen by the front and the back.
  typedef struct packed {
    logic [DimW-1:0]   nx;
    logic [PlaneW-1:0] plane;
    logic [TotW-1:0]   lim;
  } cne_geom_t;

  // One classified job: centre cell and the presence of each walk slot.
  typedef struct packed {
    logic [CellW-1:0] centre;
    logic [Slots-1:0] mask;
  } cne_job_t;

  // Walk position: plane, row and column, each coded 0..2.
  // Plane 0 is the current one, 1 the back and 2 the front plane.
  // Row and column code 0 means -1, 1 means 0 and 2 means +1.
  typedef struct packed {
    logic [1:0] p;
    logic [1:0] r;
    logic [1:0] c;
  } cne_pos_t;

  function automatic cne_pos_t cne_decode(logic [SlotW-1:0] k);
    cne_pos_t         pos;
    logic [SlotW-1:0] rem;
    logic [SlotW-1:0] crem;
    pos.p = (k >= SlotW'(18)) ? 2'd2 : (k >= SlotW'(9)) ? 2'd1 : 2'd0;
    rem   = k - ((pos.p == 2'd2) ? SlotW'(18) : (pos.p == 2'd1) ? SlotW'(9) : SlotW'(0));
    pos.r = (rem >= SlotW'(6)) ? 2'd2 : (rem >= SlotW'(3)) ? 2'd1 : 2'd0;
    crem  = rem - ((pos.r == 2'd2) ? SlotW'(6) : (pos.r == 2'd1) ? SlotW'(3) : SlotW'(0));
    pos.c = crem[1:0];
    return pos;
  endfunction

  function automatic logic cne_walled(logic [SlotW-1:0] k, logic [WallW-1:0] w);
    cne_pos_t pos;
    pos = cne_decode(k);
    return (pos.p == 2'd1 && w[WallBack])  || (pos.p == 2'd2 && w[WallFront]) ||
           (pos.r == 2'd0 && w[WallBottom]) || (pos.r == 2'd2 && w[WallTop])  ||
           (pos.c == 2'd0 && w[WallLeft])   || (pos.c == 2'd2 && w[WallRight]);
  endfunction

  function automatic logic signed [CandW-1:0] cne_cand(logic [CellW-1:0]  centre,
                                                       logic [SlotW-1:0]  k,
                                                       logic [DimW-1:0]   nx,
                                                       logic [PlaneW-1:0] plane);
    cne_pos_t                pos;
    logic signed [CandW-1:0] base;
    logic signed [CandW-1:0] roff;
    logic signed [CandW-1:0] coff;
    logic signed [CandW-1:0] poff;
    pos  = cne_decode(k);
    base = $signed({{(CandW - CellW){1'b0}}, centre});
    case (pos.r)
      2'd0:    roff = -$signed({{(CandW - DimW){1'b0}}, nx});
      2'd2:    roff = $signed({{(CandW - DimW){1'b0}}, nx});
      default: roff = '0;
    endcase
    case (pos.c)
      2'd0:    coff = {CandW{1'b1}};
      2'd2:    coff = CandW'(1);
      default: coff = '0;
    endcase
    case (pos.p)
      2'd1:    poff = $signed({{(CandW - PlaneW){1'b0}}, plane});
      2'd2:    poff = -$signed({{(CandW - PlaneW){1'b0}}, plane});
      default: poff = '0;
    endcase
    return base + roff + coff + poff;
  endfunction

endpackage

`default_nettype wire

@@ src/cne_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cne_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cne_pkg::cne_geom_t          geom_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [cne_pkg::CellW-1:0]   cell_id_i,
  input  wire logic [cne_pkg::WallW-1:0]   wall_flags_i,
  output logic                             push_valid_o,
  input  wire logic                        push_ready_i,
  output cne_pkg::cne_job_t                push_data_o
);

  logic                             busy_q;
  logic [cne_pkg::SlotW-1:0]        k_q;
  logic [cne_pkg::CellW-1:0]        centre_q;
  logic [cne_pkg::WallW-1:0]        wall_q;
  logic [cne_pkg::Slots-1:0]        mask_q;
  logic signed [cne_pkg::CandW-1:0] cand;
  logic                             pres;
  logic                             accept;
  logic                             push_fire;

  // One walk slot is classified per cycle, holding at the last until the job is pushed.
  always_comb begin
    cand = cne_pkg::cne_cand(centre_q, k_q, geom_i.nx, geom_i.plane);
    pres = !cne_pkg::cne_walled(k_q, wall_q) && !cand[cne_pkg::CandW-1] &&
           (cand < $signed({{(cne_pkg::CandW - cne_pkg::TotW){1'b0}}, geom_i.lim}));
  end

  assign push_valid_o       = busy_q && (k_q == cne_pkg::LastSlot);
  assign push_data_o.centre = centre_q;
  assign push_data_o.mask   = {pres, mask_q[cne_pkg::Slots-2:0]};
  assign push_fire          = push_valid_o && push_ready_i;
  assign in_ready_o         = !busy_q || push_fire;
  assign accept             = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      k_q    <= '0;
    end else if (push_fire) begin
      busy_q <= 1'b0;
    end else if (busy_q && k_q != cne_pkg::LastSlot) begin
      k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      centre_q <= cell_id_i;
      wall_q   <= wall_flags_i;
    end
    if (busy_q) begin
      mask_q[k_q] <= pres;
    end
  end

endmodule

`default_nettype wire

@@ src/cne_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cne_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire cne_pkg::cne_job_t push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output cne_pkg::cne_job_t      pop_data_o
);

  localparam int PtrW = (cne_pkg::QDepth > 1) ? $clog2(cne_pkg::QDepth) : 1;
  localparam int CntW = $clog2(cne_pkg::QDepth + 1);

  cne_pkg::cne_job_t mem_q [cne_pkg::QDepth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (cnt_q != CntW'(cne_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(cne_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(cne_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/cne_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cne_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cne_pkg::cne_geom_t        geom_i,
  input  wire logic                      job_valid_i,
  output logic                           job_ready_o,
  input  wire cne_pkg::cne_job_t         job_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [cne_pkg::CellW-1:0]      neighbour_cell_o,
  output logic                           present_o,
  output logic                           last_o
);

  logic                             out_valid_q;
  logic [cne_pkg::CellW-1:0]        cell_q;
  logic                             present_q;
  logic                             last_q;
  logic [cne_pkg::SlotW-1:0]        cnt_q;
  logic [cne_pkg::Slots-1:0]        done_q;
  logic [cne_pkg::Slots-1:0]        eff;
  logic [cne_pkg::SlotW-1:0]        sel;
  logic                             any;
  logic                             load;
  logic                             is_last;
  logic signed [cne_pkg::CandW-1:0] cand;

  // Slots already emitted are masked off; the lowest remaining one goes next.
  always_comb begin
    eff = job_i.mask & ~done_q;
    any = (eff != '0);
    sel = '0;
    for (int i = cne_pkg::Slots - 1; i >= 0; i--) begin
      if (eff[i]) begin
        sel = cne_pkg::SlotW'(i);
      end
    end
    cand = cne_pkg::cne_cand(job_i.centre, sel, geom_i.nx, geom_i.plane);
  end

  assign is_last     = (cnt_q == cne_pkg::LastSlot);
  assign load        = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_ready_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      done_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        if (is_last) begin
          cnt_q  <= '0;
          done_q <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
          if (any) begin
            done_q[sel] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cell_q    <= any ? cand[cne_pkg::CellW-1:0] : '0;
      present_q <= any;
      last_q    <= is_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign neighbour_cell_o = cell_q;
  assign present_o        = present_q;
  assign last_o           = last_q;

  // Padding slots never carry an index.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !present_o |-> neighbour_cell_o == '0)
    else $error("padding result with nonzero index");

  // Once padding starts in a run, no present neighbour follows before the end.
  a_pad_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !present_o && !last_o |=> !(out_valid_o && present_o))
    else $error("present neighbour after padding");

  // A job leaves the queue only together with its final result.
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready_o |=> out_valid_o && last_o && cnt_q == '0)
    else $error("job released before its last slot");

endmodule

`default_nettype wire

@@ src/cell_neighbourhood_enumerator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Flow: the front classifies an accepted item's walk slots one per cycle, holding the
// last slot while the job queue is full; the job then passes through the queue to the
// back, whose output register presents the item's results one after another.
// Throughput is bounded by the 27 results per item that leave through the single result
// port and by the front's walk, which takes a new item only as it pushes the last job.
// Reset: geometry returns to 16 x 16 cells and 4096 total, the job queue empties.

module cell_neighbourhood_enumerator_core #(
  parameter int MAX_CELLS = cne_pkg::MaxCellsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_addr_i,
  input  wire logic [cne_pkg::TotW-1:0]  cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [cne_pkg::CellW-1:0] cell_id_i,
  input  wire logic [cne_pkg::WallW-1:0] wall_flags_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [cne_pkg::CellW-1:0]      neighbour_cell_o,
  output logic                           present_o,
  output logic                           last_o
);

  // The largest index limit that still keeps every listed cell within 16 bits.
  localparam int CapLim = (MAX_CELLS < 65536) ? MAX_CELLS : 65536;

  logic [cne_pkg::DimW-1:0]   cells_x_q;
  logic [cne_pkg::DimW-1:0]   cells_y_q;
  logic [cne_pkg::TotW-1:0]   total_q;
  logic [cne_pkg::PlaneW-1:0] plane_q;
  logic [cne_pkg::TotW-1:0]   lim_q;
  logic [cne_pkg::TotW-1:0]   lim_d;
  cne_pkg::cne_geom_t         geom;

  logic                       push_valid;
  logic                       push_ready;
  cne_pkg::cne_job_t          push_data;
  logic                       job_valid;
  logic                       job_ready;
  cne_pkg::cne_job_t          job;

  // Configuration registers. Writes must arrive only while the block is idle; the block
  // does not enforce this. Derived plane size and index limit are registered from them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= cne_pkg::DimW'(16);
      cells_y_q <= cne_pkg::DimW'(16);
      total_q   <= cne_pkg::TotW'(4096);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        cne_pkg::CfgCellsX: cells_x_q <= cfg_wdata_i[cne_pkg::DimW-1:0];
        cne_pkg::CfgCellsY: cells_y_q <= cfg_wdata_i[cne_pkg::DimW-1:0];
        cne_pkg::CfgTotal:  total_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The limit saturates so that no listed index needs more than 16 bits.
  assign lim_d = (total_q > cne_pkg::TotW'(CapLim)) ? cne_pkg::TotW'(CapLim) : total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= cne_pkg::PlaneW'(256);
      lim_q   <= cne_pkg::TotW'(4096);
    end else begin
      plane_q <= {{cne_pkg::DimW{1'b0}}, cells_x_q} * {{cne_pkg::DimW{1'b0}}, cells_y_q};
      lim_q   <= lim_d;
    end
  end

  assign geom.nx    = cells_x_q;
  assign geom.plane = plane_q;
  assign geom.lim   = lim_q;

  // Front: takes an item and classifies all 27 walk slots into a presence mask.
  cne_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cell_id_i    (cell_id_i),
    .wall_flags_i (wall_flags_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Short queue so the front can classify the next item while results drain.
  cne_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_ready),
    .pop_data_o   (job)
  );

  // Back: emits present neighbours in walk order, then padding, 27 in all.
  cne_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .geom_i           (geom),
    .job_valid_i      (job_valid),
    .job_ready_o      (job_ready),
    .job_i            (job),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .neighbour_cell_o (neighbour_cell_o),
    .present_o        (present_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the cell neighbourhood enumerator. Every query sent in is
// expanded here into its 27 expected slots, and every slot that leaves the
// block is checked against the oldest one still waiting. Grid geometry is
// changed only while nothing is in flight.
module tb_top;

  // The one register index that the block does not decode; writes to it must
  // leave the geometry untouched.
  localparam logic [1:0] CfgSpare = 2'd3;

  // Delay from the acceptance of a query until its first slot can be taken.
  localparam int Latency = 29;

  // Cycles with no item moving on either channel before the run is declared
  // hung. The slowest legal gap is the longest sender pause, the block's own
  // latency and a long receiver stall, far below this.
  localparam int HangLimit = 4000;

  localparam int PhaseCount = 8;
  localparam int PhaseItems = 50;

  // One result slot as the block presents it.
  typedef struct packed {
    logic [cne_pkg::CellW-1:0] neighbour_cell;
    logic                      present;
    logic                      is_last;
  } slot_t;

  // Keeps a private copy of the geometry, turns each accepted query into its
  // run of 27 slots and checks the slots that the block hands out.
  class neighbour_scoreboard;
    logic [cne_pkg::DimW-1:0] nx;
    logic [cne_pkg::DimW-1:0] ny;
    logic [cne_pkg::TotW-1:0] total;
    slot_t                    expected_slots[$];
    int                       errors;

    function new();
      nx     = 16;
      ny     = 16;
      total  = 4096;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [cne_pkg::TotW-1:0] value);
      case (idx)
        cne_pkg::CfgCellsX: nx = value[cne_pkg::DimW-1:0];
        cne_pkg::CfgCellsY: ny = value[cne_pkg::DimW-1:0];
        cne_pkg::CfgTotal:  total = value;
        default:   ;
      endcase
    endfunction

    // Walk current, back and front plane, rows -1..+1, columns -1..+1, and
    // keep every candidate whose side is open and whose index is in range.
    function void note_query(logic [cne_pkg::CellW-1:0] centre,
                             logic [cne_pkg::WallW-1:0] walls);
      longint lim;
      longint plane;
      longint cand;
      longint poff[3];
      bit     pon[3];
      int     count;
      slot_t  s;
      lim = longint'(total);
      if (lim > longint'(cne_pkg::MaxCellsDef)) lim = longint'(cne_pkg::MaxCellsDef);
      if (lim > 65536) lim = 65536;
      plane   = longint'(nx) * longint'(ny);
      poff[0] = 0;
      poff[1] = plane;
      poff[2] = -plane;
      pon[0]  = 1'b1;
      pon[1]  = !walls[cne_pkg::WallBack];
      pon[2]  = !walls[cne_pkg::WallFront];
      count   = 0;
      for (int p = 0; p < 3; p++) begin
        if (!pon[p]) continue;
        for (int r = -1; r <= 1; r++) begin
          if (r < 0 && walls[cne_pkg::WallBottom]) continue;
          if (r > 0 && walls[cne_pkg::WallTop]) continue;
          for (int c = -1; c <= 1; c++) begin
            if (c < 0 && walls[cne_pkg::WallLeft]) continue;
            if (c > 0 && walls[cne_pkg::WallRight]) continue;
            cand = longint'(centre) + longint'(r) * longint'(nx) + longint'(c) + poff[p];
            if (cand < 0 || cand >= lim || count >= cne_pkg::Slots) continue;
            s.neighbour_cell = cand[cne_pkg::CellW-1:0];
            s.present        = 1'b1;
            s.is_last        = (count == cne_pkg::Slots - 1);
            expected_slots.push_back(s);
            count++;
          end
        end
      end
      // Padding fills the remainder of the run; the final slot carries last.
      while (count < cne_pkg::Slots) begin
        s.neighbour_cell = '0;
        s.present        = 1'b0;
        s.is_last        = (count == cne_pkg::Slots - 1);
        expected_slots.push_back(s);
        count++;
      end
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_slot(slot_t got);
      slot_t want;
      if (expected_slots.size() == 0) begin
        report($sformatf("result with nothing expected: cell %0d present %0b last %0b",
                         got.neighbour_cell, got.present, got.is_last));
        return;
      end
      want = expected_slots.pop_front();
      if (got.neighbour_cell !== want.neighbour_cell)
        report($sformatf("neighbour_cell %0d, expected %0d",
                         got.neighbour_cell, want.neighbour_cell));
      if (got.present !== want.present)
        report($sformatf("present %0b, expected %0b", got.present, want.present));
      if (got.is_last !== want.is_last)
        report($sformatf("last %0b, expected %0b", got.is_last, want.is_last));
    endtask
  endclass

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      cfg_we_i     = 1'b0;
  logic [1:0]                cfg_addr_i   = '0;
  logic [cne_pkg::TotW-1:0]  cfg_wdata_i  = '0;
  logic                      in_valid_i   = 1'b0;
  logic [cne_pkg::CellW-1:0] cell_id_i    = '0;
  logic [cne_pkg::WallW-1:0] wall_flags_i = '0;
  logic                      out_ready_i  = 1'b0;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic [cne_pkg::CellW-1:0] neighbour_cell_o;
  logic                      present_o;
  logic                      last_o;

  // When set, neither side inserts idle cycles.
  bit                        idle_free    = 1'b0;
  int                        hang_count   = 0;
  neighbour_scoreboard       sb;

  cell_neighbourhood_enumerator_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cell_id_i        (cell_id_i),
    .wall_flags_i     (wall_flags_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .neighbour_cell_o (neighbour_cell_o),
    .present_o        (present_o),
    .last_o           (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Result side. Outputs are read at the edge before any register in the
  // block moves, and ready is updated with a nonblocking assignment, so the
  // handshake seen here is exactly the one the block sees.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_slot('{neighbour_cell: neighbour_cell_o, present: present_o,
                      is_last: last_o});
    out_ready_i <= idle_free ? 1'b1 : ($urandom_range(0, 99) >= 35);
  end

  // Hang detection: any accepted item on either channel clears the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      hang_count <= 0;
    else
      hang_count <= hang_count + 1;
    if (hang_count >= HangLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one query and hold it until the block takes it. Valid is left high
  // afterwards so that back-to-back queries keep it high without a gap.
  task automatic send_query(input logic [cne_pkg::CellW-1:0] centre,
                            input logic [cne_pkg::WallW-1:0] walls);
    int gap;
    gap = 0;
    if (!idle_free && $urandom_range(0, 99) < 35) gap = $urandom_range(1, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cell_id_i    <= centre;
    wall_flags_i <= walls;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_query(centre, walls);
  endtask

  // Drop valid and wait until every slot still owed has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_slots.size() != 0) @(posedge clk_i);
  endtask

  // One register write; the enable is lowered after the write is taken and the task
  // ends at the next edge: consecutive writes never assign it twice in one time step.
  task automatic write_reg(input logic [1:0] idx, input logic [cne_pkg::TotW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [cne_pkg::TotW-1:0] nx,
                              input logic [cne_pkg::TotW-1:0] ny,
                              input logic [cne_pkg::TotW-1:0] total);
    drain();
    write_reg(cne_pkg::CfgCellsX, nx);
    write_reg(cne_pkg::CfgCellsY, ny);
    write_reg(cne_pkg::CfgTotal, total);
  endtask

  // Grid size along one axis: mostly the extremes and common sizes, sometimes
  // with junk in the bits above the register width.
  function automatic logic [cne_pkg::TotW-1:0] pick_dim();
    logic [cne_pkg::TotW-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 1;
      2:       v = 511;
      3:       v = 256;
      4:       v = 16;
      default: v = cne_pkg::TotW'($urandom_range(1, 64));
    endcase
    if ($urandom_range(0, 4) == 0)
      v = v | (cne_pkg::TotW'($urandom_range(0, 255)) << cne_pkg::DimW);
    return v;
  endfunction

  function automatic logic [cne_pkg::TotW-1:0] pick_total();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 65535;
      3:       return 65536;
      4:       return 131071;
      5:       return cne_pkg::TotW'($urandom_range(65537, 131071));
      default: return cne_pkg::TotW'($urandom_range(8, 65536));
    endcase
  endfunction

  // Centre cells cluster near both ends of the valid range, where the range
  // test bites, with the rest spread over the range and over all 16 bits.
  function automatic logic [cne_pkg::CellW-1:0] pick_centre();
    longint lim;
    longint v;
    int     sel;
    lim = (sb.total > 65536) ? 65536 : longint'(sb.total);
    sel = $urandom_range(0, 99);
    if (lim == 0 || sel < 25) begin
      v = longint'($urandom_range(0, 65535));
    end else if (sel < 45) begin
      v = longint'($urandom_range(0, 600));
    end else if (sel < 65) begin
      v = lim - 1 - longint'($urandom_range(0, 600));
      if (v < 0) v = 0;
    end else begin
      v = longint'($urandom_range(0, int'(lim - 1)));
    end
    return v[cne_pkg::CellW-1:0];
  endfunction

  // Walls: open, a single side, or any mix of the six.
  function automatic logic [cne_pkg::WallW-1:0] pick_walls();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return '0;
    if (sel < 45) return cne_pkg::WallW'(1) << $urandom_range(0, cne_pkg::WallW - 1);
    return cne_pkg::WallW'($urandom_range(0, 63));
  endfunction

  initial begin : stimulus
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed queries on the reset geometry of 16 x 16 cells, 4096 in total.
    send_query(16'd0, 6'h00);        // corner: front plane and four more candidates below zero
    send_query(16'd4095, 6'h00);     // top corner: back plane and four more beyond the limit
    send_query(16'd2000, 6'h00);     // interior: all 27 present
    send_query(16'd2000, 6'h3F);     // every side walled: only the centre
    for (int b = 0; b < cne_pkg::WallW; b++)
      send_query(16'd2000, cne_pkg::WallW'(1) << b);
    send_query(16'd2000, 6'h30);     // back and front walled: current plane only
    send_query(16'd4096, 6'h00);     // centre itself out of range
    send_query(16'hFFFF, 6'h00);
    send_query(16'hFFFF, 6'h3F);

    // An empty grid gives nothing but padding.
    set_geometry(17'd16, 17'd16, 17'd0);
    send_query(16'd0, 6'h00);
    send_query(16'd100, 6'h15);

    // A total above 65536 saturates, so the top cell id is in range.
    set_geometry(17'd256, 17'd256, 17'h1FFFF);
    send_query(16'hFFFF, 6'h00);
    send_query(16'd0, 6'h00);
    send_query(16'hFF00, 6'h0A);

    // Zero sized axes make candidates coincide; they are listed again.
    set_geometry(17'd0, 17'd0, 17'd65536);
    send_query(16'd5, 6'h00);

    // Widest axes, written with all upper data bits set.
    set_geometry(17'h1FFFF, 17'h1FFFF, 17'd65535);
    send_query(16'd30000, 6'h00);
    send_query(16'hFFFE, 6'h00);

    // The unused index must leave this tiny grid as it is.
    set_geometry(17'd1, 17'd1, 17'd1);
    write_reg(CfgSpare, 17'h1FFFF);
    send_query(16'd0, 6'h00);

    // Random phases, each on a fresh geometry. One phase runs without idle
    // cycles on either side, and once the sender holds off mid-phase until
    // every slot owed has been delivered.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      set_geometry(pick_dim(), pick_dim(), pick_total());
      idle_free = (ph == 3);
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 1 && i == PhaseItems / 2) drain();
        send_query(pick_centre(), pick_walls());
      end
    end
    idle_free = 1'b0;

    drain();
    repeat (Latency + 10) @(posedge clk_i);
    if (sb.expected_slots.size() != 0)
      sb.report($sformatf("%0d slots never delivered", sb.expected_slots.size()));

    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
